[hw/rtl/gxyb_pkg.sv]
// ---------------------------------------------------------------------------
// gxyb_pkg: shared types and constants of the G-code XY bounds checker
// Character codes, register indexes, reset limits and the per-line summary.
// ---------------------------------------------------------------------------
`default_nettype none

package gxyb_pkg;

	// Field widths.
	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 25;
	localparam int MAG_W   = 24;
	localparam int CFG_IDX_W = 2;

	typedef logic [CHAR_W-1:0]          char_t;
	typedef logic signed [VALUE_W-1:0]  value_t;
	typedef logic [MAG_W-1:0]           mag_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_X_LOW  = 2'd0;
	localparam cfg_idx_t REG_X_HIGH = 2'd1;
	localparam cfg_idx_t REG_Y_LOW  = 2'd2;
	localparam cfg_idx_t REG_Y_HIGH = 2'd3;

	// Window limits after reset, in thousandths of a unit.
	localparam value_t X_LOW_RESET  = 25'sd28000;
	localparam value_t X_HIGH_RESET = 25'sd192000;
	localparam value_t Y_LOW_RESET  = 25'sd38000;
	localparam value_t Y_HIGH_RESET = 25'sd242000;

	// Characters the scanner reacts to.
	localparam char_t CH_X     = 8'h58;
	localparam char_t CH_Y     = 8'h59;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_POINT = 8'h2E;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;

	// What the parser knows about a line once its last character is taken.
	typedef struct packed {
		logic   x_found;
		logic   y_found;
		value_t x_value;
		value_t y_value;
		logic   malformed;
	} line_sum_t;

endpackage

`default_nettype wire

[hw/rtl/gxyb_char_if.sv]
// ---------------------------------------------------------------------------
// gxyb_char_if: character stream channel
// Valid/ready channel carrying one character of a command line per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface gxyb_char_if;
	logic                 valid;
	logic                 ready;
	gxyb_pkg::char_t      line_byte;
	logic                 last_byte;

	modport source (output valid, output line_byte, output last_byte, input ready);
	modport sink   (input valid, input line_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/gxyb_result_if.sv]
// ---------------------------------------------------------------------------
// gxyb_result_if: line result channel
// Valid/ready channel carrying the parsed coordinates and flags of one line.
// ---------------------------------------------------------------------------
`default_nettype none

interface gxyb_result_if;
	logic                 valid;
	logic                 ready;
	logic                 in_window;
	logic                 x_found;
	logic                 y_found;
	gxyb_pkg::value_t     x_value;
	gxyb_pkg::value_t     y_value;
	logic                 malformed;

	modport source (output valid, output in_window, output x_found, output y_found,
		output x_value, output y_value, output malformed, input ready);
	modport sink   (input valid, input in_window, input x_found, input y_found,
		input x_value, input y_value, input malformed, output ready);
endinterface

`default_nettype wire

[hw/rtl/gxyb_parser.sv]
// ---------------------------------------------------------------------------
// gxyb_parser: per-line X/Y word scanner
// Holds the line state and folds in one character per enabled cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module gxyb_parser #(
	parameter int LINE_BYTES      = 64,
	parameter int FRACTION_DIGITS = 3,
	parameter int INTEGER_DIGITS  = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire gxyb_pkg::char_t     line_byte,
	input  wire logic                last_byte,
	output gxyb_pkg::line_sum_t      summary
);

	localparam int POS_W = $clog2(LINE_BYTES + 1);
	localparam gxyb_pkg::mag_t SAT_MAG =
		gxyb_pkg::MAG_W'((10 ** INTEGER_DIGITS - 1) * 1000);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SIGN = 2'd1;
	localparam logic [1:0] PH_NUM  = 2'd2;

	logic [1:0]        phase_q, n_phase;
	logic              axis_q, n_axis;
	gxyb_pkg::value_t  x_acc_q, y_acc_q, n_x_acc, n_y_acc;
	logic              x_seen_q, y_seen_q, n_x_seen, n_y_seen;
	gxyb_pkg::mag_t    mag_q, n_mag;
	logic              neg_q, n_neg;
	logic              point_q, n_point;
	logic [1:0]        frac_q, n_frac;
	logic [2:0]        int_q, n_int;
	logic [POS_W-1:0]  pos_q, n_pos;
	logic              err_q, n_err;

	logic              num_char;
	logic              finish;
	logic              is_digit;
	logic [3:0]        digit;
	gxyb_pkg::mag_t    frac_add;
	gxyb_pkg::value_t  word_val;

	assign is_digit = (line_byte >= gxyb_pkg::CH_ZERO) && (line_byte <= gxyb_pkg::CH_NINE);
	assign digit    = line_byte[3:0];

	always_comb begin
		n_phase  = phase_q;
		n_axis   = axis_q;
		n_x_acc  = x_acc_q;
		n_y_acc  = y_acc_q;
		n_x_seen = x_seen_q;
		n_y_seen = y_seen_q;
		n_mag    = mag_q;
		n_neg    = neg_q;
		n_point  = point_q;
		n_frac   = frac_q;
		n_int    = int_q;
		n_pos    = pos_q;
		n_err    = err_q;
		num_char = 1'b0;
		finish   = 1'b0;
		frac_add = '0;
		word_val = '0;

		// Characters past the line limit only mark the line as bad.
		if (pos_q >= POS_W'(LINE_BYTES)) begin
			n_err = 1'b1;
		end else begin
			n_pos = pos_q + POS_W'(1);
			case (phase_q)
				PH_IDLE: begin
					if (line_byte == gxyb_pkg::CH_X && !x_seen_q) begin
						n_axis  = 1'b0;
						n_phase = PH_SIGN;
					end else if (line_byte == gxyb_pkg::CH_Y && !y_seen_q) begin
						n_axis  = 1'b1;
						n_phase = PH_SIGN;
					end
				end
				PH_SIGN: begin
					n_phase = PH_NUM;
					if (line_byte == gxyb_pkg::CH_MINUS) begin
						n_neg = 1'b1;
					end else begin
						num_char = 1'b1;
					end
				end
				default: begin
					num_char = 1'b1;
				end
			endcase
		end

		if (num_char) begin
			if (is_digit) begin
				if (point_q) begin
					if ({1'b0, frac_q} < 3'(FRACTION_DIGITS)) begin
						n_frac = frac_q + 2'd1;
						case (n_frac)
							2'd1:    frac_add = gxyb_pkg::MAG_W'(digit) * gxyb_pkg::MAG_W'(100);
							2'd2:    frac_add = gxyb_pkg::MAG_W'(digit) * gxyb_pkg::MAG_W'(10);
							default: frac_add = gxyb_pkg::MAG_W'(digit);
						endcase
						n_mag = mag_q + frac_add;
					end
				end else if (int_q > 3'(INTEGER_DIGITS)) begin
					n_mag = mag_q;
				end else if (mag_q == '0 && digit == 4'd0) begin
					n_mag = mag_q;
				end else if (int_q >= 3'(INTEGER_DIGITS)) begin
					n_mag = SAT_MAG;
					n_int = 3'(INTEGER_DIGITS + 1);
				end else begin
					n_mag = gxyb_pkg::MAG_W'(mag_q * gxyb_pkg::MAG_W'(10))
						+ gxyb_pkg::MAG_W'(digit) * gxyb_pkg::MAG_W'(1000);
					n_int = int_q + 3'd1;
				end
			end else if (line_byte == gxyb_pkg::CH_POINT && !point_q) begin
				n_point = 1'b1;
			end else if (line_byte == gxyb_pkg::CH_SPACE) begin
				finish = 1'b1;
			end else begin
				n_err  = 1'b1;
				finish = 1'b1;
			end
		end

		// The line end closes any word still open.
		if (last_byte && n_phase != PH_IDLE) begin
			finish = 1'b1;
		end

		if (finish) begin
			word_val = n_neg ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
			if (!n_axis) begin
				n_x_acc  = word_val;
				n_x_seen = 1'b1;
			end else begin
				n_y_acc  = word_val;
				n_y_seen = 1'b1;
			end
			n_phase = PH_IDLE;
			n_mag   = '0;
			n_neg   = 1'b0;
			n_point = 1'b0;
			n_frac  = 2'd0;
			n_int   = 3'd0;
		end
	end

	assign summary = '{
		x_found:   n_x_seen,
		y_found:   n_y_seen,
		x_value:   n_x_acc,
		y_value:   n_y_acc,
		malformed: n_err
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			axis_q   <= 1'b0;
			x_acc_q  <= '0;
			y_acc_q  <= '0;
			x_seen_q <= 1'b0;
			y_seen_q <= 1'b0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			point_q  <= 1'b0;
			frac_q   <= 2'd0;
			int_q    <= 3'd0;
			pos_q    <= '0;
			err_q    <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				phase_q  <= PH_IDLE;
				axis_q   <= 1'b0;
				x_acc_q  <= '0;
				y_acc_q  <= '0;
				x_seen_q <= 1'b0;
				y_seen_q <= 1'b0;
				mag_q    <= '0;
				neg_q    <= 1'b0;
				point_q  <= 1'b0;
				frac_q   <= 2'd0;
				int_q    <= 3'd0;
				pos_q    <= '0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= n_phase;
				axis_q   <= n_axis;
				x_acc_q  <= n_x_acc;
				y_acc_q  <= n_y_acc;
				x_seen_q <= n_x_seen;
				y_seen_q <= n_y_seen;
				mag_q    <= n_mag;
				neg_q    <= n_neg;
				point_q  <= n_point;
				frac_q   <= n_frac;
				int_q    <= n_int;
				pos_q    <= n_pos;
				err_q    <= n_err;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/gcode_xy_bounds_checker_top.sv]
// ---------------------------------------------------------------------------
// gcode_xy_bounds_checker_top: G-code line XY window checker
// Scans a command line character by character for the first X and Y words
// and reports both values and whether they lie inside the programmed window.
// ---------------------------------------------------------------------------
//
//   Channel     Direction  Handshake    Contents
//   char_ch     sink       valid/ready  line_byte, last_byte (one character)
//   result_ch   source     valid/ready  in_window, x_found, y_found,
//                                       x_value, y_value, malformed
//   cfg_*       sink       write enable limits x_low, x_high, y_low, y_high
//
// The block takes one character per clock cycle unless its input is stalled.
// An accepted character is held in the input register, where the parser folds
// it into the line state; the last character of a line then loads the result
// register, which offers the result on the result channel.
// Reset clears the line state and loads the default window limits.
// A stall on the result channel holds the input register only while it holds
// a last character that needs the occupied result register; characters of a
// line in progress keep flowing until then.
`default_nettype none

module gcode_xy_bounds_checker_top #(
	parameter int LINE_BYTES      = 64,
	parameter int FRACTION_DIGITS = 3,
	parameter int INTEGER_DIGITS  = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	gxyb_char_if.sink                   char_ch,
	gxyb_result_if.source               result_ch,
	input  wire logic                   cfg_write_en,
	input  wire gxyb_pkg::cfg_idx_t     cfg_index,
	input  wire gxyb_pkg::value_t       cfg_data
);

	// Window limits, written through the configuration port.
	gxyb_pkg::value_t x_low_q, x_high_q, y_low_q, y_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= gxyb_pkg::X_LOW_RESET;
			x_high_q <= gxyb_pkg::X_HIGH_RESET;
			y_low_q  <= gxyb_pkg::Y_LOW_RESET;
			y_high_q <= gxyb_pkg::Y_HIGH_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				gxyb_pkg::REG_X_LOW:  x_low_q  <= cfg_data;
				gxyb_pkg::REG_X_HIGH: x_high_q <= cfg_data;
				gxyb_pkg::REG_Y_LOW:  y_low_q  <= cfg_data;
				gxyb_pkg::REG_Y_HIGH: y_high_q <= cfg_data;
				default:              x_low_q  <= x_low_q;
			endcase
		end
	end

	// Input register. The held character moves on unless it ends a line
	// while the result register still waits for the sink.
	logic             valid_s1;
	gxyb_pkg::char_t  byte_s1;
	logic             last_s1;
	logic             advance;
	logic             res_valid_q;

	assign advance       = valid_s1 && (!last_s1 || !res_valid_q || result_ch.ready);
	assign char_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ch.ready) begin
			valid_s1 <= char_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.valid && char_ch.ready) begin
			byte_s1 <= char_ch.line_byte;
			last_s1 <= char_ch.last_byte;
		end
	end

	// Line scanner; its summary already includes the character being folded in.
	gxyb_pkg::line_sum_t summary;

	gxyb_parser #(
		.LINE_BYTES      (LINE_BYTES),
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.INTEGER_DIGITS  (INTEGER_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.line_byte (byte_s1),
		.last_byte (last_s1),
		.summary   (summary)
	);

	// Window check: an absent axis passes, reversed limits fail a found value.
	logic x_out, y_out, window_ok;

	assign x_out     = summary.x_found &&
		((summary.x_value < x_low_q) || (summary.x_value > x_high_q));
	assign y_out     = summary.y_found &&
		((summary.y_value < y_low_q) || (summary.y_value > y_high_q));
	assign window_ok = !summary.malformed && !x_out && !y_out;

	// Result register.
	logic             in_window_q, x_found_q, y_found_q, malformed_q;
	gxyb_pkg::value_t x_value_q, y_value_q;
	logic             load_result;

	assign load_result = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_result) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			in_window_q <= window_ok;
			x_found_q   <= summary.x_found;
			y_found_q   <= summary.y_found;
			x_value_q   <= summary.x_value;
			y_value_q   <= summary.y_value;
			malformed_q <= summary.malformed;
		end
	end

	assign result_ch.valid     = res_valid_q;
	assign result_ch.in_window = in_window_q;
	assign result_ch.x_found   = x_found_q;
	assign result_ch.y_found   = y_found_q;
	assign result_ch.x_value   = x_value_q;
	assign result_ch.y_value   = y_value_q;
	assign result_ch.malformed = malformed_q;

endmodule

`default_nettype wire

[hw/rtl/gxyb_checker.sv]
// ---------------------------------------------------------------------------
// gxyb_checker: port-level assertions for the XY bounds checker
// Watches the result channel of the top level and is bound to it.
// ---------------------------------------------------------------------------
`default_nettype none

module gxyb_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic              in_window,
	input wire logic              x_found,
	input wire logic              y_found,
	input wire gxyb_pkg::value_t  x_value,
	input wire gxyb_pkg::value_t  y_value,
	input wire logic              malformed
);

	// A stalled result stays offered and unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(x_value) && $stable(y_value)
			&& $stable(in_window) && $stable(malformed))
		else $error("result changed while stalled");

	// A malformed line never passes the window check.
	a_malformed_fails: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && malformed |-> !in_window)
		else $error("malformed line reported in window");

	// An axis that was not found reads as zero.
	a_x_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !x_found |-> x_value == '0)
		else $error("absent X has nonzero value");

	a_y_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !y_found |-> y_value == '0)
		else $error("absent Y has nonzero value");

endmodule

bind gcode_xy_bounds_checker_top gxyb_checker u_gxyb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result_ch.valid),
	.res_ready (result_ch.ready),
	.in_window (result_ch.in_window),
	.x_found   (result_ch.x_found),
	.y_found   (result_ch.y_found),
	.x_value   (result_ch.x_value),
	.y_value   (result_ch.y_value),
	.malformed (result_ch.malformed)
);

`default_nettype wire

[verif/tb_gcode_xy_bounds_checker_top.sv]
// ---------------------------------------------------------------------------
// tb_gcode_xy_bounds_checker_top: self-checking bench for the XY window checker
// Streams command lines into the block one character at a time, predicts the
// per-line verdict with a behavioral parser, and checks every result field.
// ---------------------------------------------------------------------------

module tb_gcode_xy_bounds_checker_top;

	localparam int LINE_BYTES      = 64;
	localparam int FRACTION_DIGITS = 3;
	localparam int INTEGER_DIGITS  = 4;

	// The result side is held off this long once, so that the result register
	// stays full and the block has to push back on the character stream.
	localparam int HOLD_CYCLES = 400;

	// Bound on how long a phase waits for results after its last character.
	localparam int DRAIN_CYCLES = 1000;

	// One character waiting to be sent.
	typedef struct packed {
		gxyb_pkg::char_t code;
		logic            last;
	} line_char_t;

	// The expected verdict for one line.
	typedef struct packed {
		logic                in_window;
		gxyb_pkg::line_sum_t sum;
	} line_verdict_t;

	// Where the parser is inside the current word.
	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_SIGN,
		SCAN_NUM
	} scan_phase_e;

	logic clk = 1'b0;
	logic arst_n;

	logic               cfg_write_en;
	gxyb_pkg::cfg_idx_t cfg_index;
	gxyb_pkg::value_t   cfg_data;

	gxyb_char_if   char_bus ();
	gxyb_result_if result_bus ();

	gcode_xy_bounds_checker_top #(
		.LINE_BYTES      (LINE_BYTES),
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.INTEGER_DIGITS  (INTEGER_DIGITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_ch      (char_bus),
		.result_ch    (result_bus),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Characters not yet accepted by the block, oldest first.
	line_char_t char_queue [$];
	// Verdicts of lines whose last character went in but whose result has
	// not come out yet.
	line_verdict_t line_results_due [$];

	// Sender and receiver pacing. char_busy is set while an item is on offer
	// and cleared by the monitor when the block takes it.
	bit idle_enable;
	bit char_busy;
	int char_gap;
	int ready_gap;
	bit hold_request;
	int hold_left;

	int chars_queued;
	int chars_taken;
	int lines_checked;
	int lines_in_window;
	int lines_malformed;
	int mismatches;

	// Shadow of the window registers, indexed by register index.
	gxyb_pkg::value_t window_limit [4];

	// Shadow of the line parser.
	scan_phase_e      scan;
	logic             axis_is_y;
	gxyb_pkg::value_t x_word;
	gxyb_pkg::value_t y_word;
	logic             x_seen;
	logic             y_seen;
	logic             word_negative;
	logic             word_point;
	logic             line_bad;
	int unsigned      word_mag;
	int               frac_digits;
	int               int_digits;
	int               line_pos;

	function automatic void clear_word();
		scan          = SCAN_IDLE;
		word_mag      = 0;
		word_negative = 1'b0;
		word_point    = 1'b0;
		frac_digits   = 0;
		int_digits    = 0;
	endfunction

	function automatic void start_line();
		clear_word();
		axis_is_y = 1'b0;
		x_word    = '0;
		y_word    = '0;
		x_seen    = 1'b0;
		y_seen    = 1'b0;
		line_pos  = 0;
		line_bad  = 1'b0;
	endfunction

	// Stores the word read so far into its axis and marks the axis as found.
	function automatic void close_word();
		gxyb_pkg::value_t v;
		v = gxyb_pkg::value_t'(word_mag);
		if (word_negative) begin
			v = -v;
		end
		if (axis_is_y) begin
			y_word = v;
			y_seen = 1'b1;
		end else begin
			x_word = v;
			x_seen = 1'b1;
		end
		clear_word();
	endfunction

	// One character inside a number. Fraction digits beyond the kept ones are
	// dropped; leading zeros do not count toward the integer digits, and one
	// digit too many pins the integer part to all nines.
	function automatic void fold_number_char(input gxyb_pkg::char_t c);
		int unsigned d;
		if (c >= gxyb_pkg::CH_ZERO && c <= gxyb_pkg::CH_NINE) begin
			d = c - gxyb_pkg::CH_ZERO;
			if (word_point) begin
				if (frac_digits < FRACTION_DIGITS) begin
					frac_digits++;
					word_mag += d * (10 ** (3 - frac_digits));
				end
			end else if (int_digits <= INTEGER_DIGITS && !(word_mag == 0 && d == 0)) begin
				if (int_digits == INTEGER_DIGITS) begin
					word_mag   = (10 ** INTEGER_DIGITS - 1) * 1000;
					int_digits = INTEGER_DIGITS + 1;
				end else begin
					word_mag = word_mag * 10 + d * 1000;
					int_digits++;
				end
			end
		end else if (c == gxyb_pkg::CH_POINT && !word_point) begin
			word_point = 1'b1;
		end else if (c == gxyb_pkg::CH_SPACE) begin
			close_word();
		end else begin
			// Anything else ends the word with what was read and spoils the line.
			line_bad = 1'b1;
			close_word();
		end
	endfunction

	// Folds one accepted character into the shadow parser and, on the last
	// character of a line, queues the verdict the block must report.
	function automatic void parse_char(input gxyb_pkg::char_t c, input logic last);
		line_verdict_t r;
		if (line_pos >= LINE_BYTES) begin
			line_bad = 1'b1;
		end else begin
			line_pos++;
			case (scan)
				SCAN_IDLE: begin
					if (c == gxyb_pkg::CH_X && !x_seen) begin
						axis_is_y = 1'b0;
						scan      = SCAN_SIGN;
					end else if (c == gxyb_pkg::CH_Y && !y_seen) begin
						axis_is_y = 1'b1;
						scan      = SCAN_SIGN;
					end
				end
				SCAN_SIGN: begin
					scan = SCAN_NUM;
					if (c == gxyb_pkg::CH_MINUS) begin
						word_negative = 1'b1;
					end else begin
						fold_number_char(c);
					end
				end
				default: begin
					fold_number_char(c);
				end
			endcase
		end
		if (last) begin
			if (scan != SCAN_IDLE) begin
				close_word();
			end
			r.in_window = !line_bad;
			if (x_seen && (x_word < window_limit[gxyb_pkg::REG_X_LOW] ||
					x_word > window_limit[gxyb_pkg::REG_X_HIGH])) begin
				r.in_window = 1'b0;
			end
			if (y_seen && (y_word < window_limit[gxyb_pkg::REG_Y_LOW] ||
					y_word > window_limit[gxyb_pkg::REG_Y_HIGH])) begin
				r.in_window = 1'b0;
			end
			r.sum.x_found   = x_seen;
			r.sum.y_found   = y_seen;
			r.sum.x_value   = x_word;
			r.sum.y_value   = y_word;
			r.sum.malformed = line_bad;
			line_results_due.push_back(r);
			start_line();
		end
	endfunction

	function automatic void compare_field(input string field, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	function automatic void add_char(input gxyb_pkg::char_t c, input logic last);
		line_char_t item;
		item.code = c;
		item.last = last;
		char_queue.push_back(item);
		chars_queued++;
	endfunction

	// Sends a text as one line: its final character carries the last flag.
	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(gxyb_pkg::char_t'(s[i]), i == s.len() - 1);
		end
	endfunction

	// Text of one number: either a value right at, just below or just above
	// one of the current window limits, or a free mix of sign, integer digits
	// (with leading zeros and overlong parts), point and fraction digits.
	function automatic string number_text();
		string t;
		string sign;
		int    v;
		t    = "";
		sign = "";
		if ($urandom_range(0, 3) == 0) begin
			v = int'(window_limit[$urandom_range(0, 3)]) + int'($urandom_range(0, 2)) - 1;
			if (v < 0) begin
				sign = "-";
				v    = -v;
			end
			t = $sformatf("%s%0d.%03d", sign, v / 1000, v % 1000);
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				t = "-";
			end
			repeat ($urandom_range(0, 6)) begin
				t = {t, $sformatf("%0d", $urandom_range(0, 9))};
			end
			if ($urandom_range(0, 9) < 6) begin
				t = {t, "."};
				repeat ($urandom_range(0, 5)) begin
					t = {t, $sformatf("%0d", $urandom_range(0, 9))};
				end
			end
		end
		return t;
	endfunction

	// Most lines are well formed commands with random numbers; a few carry a
	// stray character, a repeated axis or padding past the search limit, and
	// some are plain byte noise.
	function automatic void queue_random_line();
		string s;
		string word;
		string strays;
		int    kind;
		int    n;
		int    pad_to;
		bit    y_first;
		strays = "-.XYZa#,";
		kind   = $urandom_range(0, 99);
		if (kind < 8) begin
			n = (kind == 0) ? $urandom_range(LINE_BYTES + 1, LINE_BYTES + 26)
				: $urandom_range(1, 20);
			for (int i = 0; i < n; i++) begin
				add_char(gxyb_pkg::char_t'($urandom_range(0, 255)), i == n - 1);
			end
		end else begin
			s = "";
			if ($urandom_range(0, 1) != 0) begin
				s = "G1 ";
			end
			y_first = 1'($urandom_range(0, 1));
			for (int k = 0; k < 2; k++) begin
				if ($urandom_range(0, 6) != 0) begin
					word = "X";
					if ((k == 1) ^ y_first) begin
						word = "Y";
					end
					word = {word, number_text()};
					if ($urandom_range(0, 11) == 0) begin
						word = {word, $sformatf("%c%0d", strays[$urandom_range(0, 7)],
							$urandom_range(0, 99))};
					end
					s = {s, word, " "};
				end
			end
			if ($urandom_range(0, 7) == 0) begin
				word = "Y";
				if ($urandom_range(0, 1) != 0) begin
					word = "X";
				end
				s = {s, word, number_text(), " "};
			end
			if ($urandom_range(0, 2) == 0) begin
				s = {s, "F1500 "};
			end
			if ($urandom_range(0, 15) == 0) begin
				pad_to = $urandom_range(LINE_BYTES - 4, LINE_BYTES + 20);
				while (s.len() < pad_to) begin
					s = {s, " "};
				end
				s = {s, "Y1"};
			end
			// Half the lines end right on a number instead of on a space.
			if ($urandom_range(0, 1) != 0 && s.len() > 1) begin
				s = s.substr(0, s.len() - 2);
			end
			if (s.len() == 0) begin
				s = "G";
			end
			queue_text(s);
		end
	endfunction

	function automatic void queue_random_lines(input int budget);
		int mark;
		mark = chars_queued;
		while (chars_queued - mark < budget) begin
			queue_random_line();
		end
	endfunction

	task automatic write_limit(input gxyb_pkg::cfg_idx_t idx, input gxyb_pkg::value_t v);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= v;
		@(posedge clk);
		window_limit[idx] = v;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic write_window(input gxyb_pkg::value_t x_lo, input gxyb_pkg::value_t x_hi,
		input gxyb_pkg::value_t y_lo, input gxyb_pkg::value_t y_hi);
		write_limit(gxyb_pkg::REG_X_LOW, x_lo);
		write_limit(gxyb_pkg::REG_X_HIGH, x_hi);
		write_limit(gxyb_pkg::REG_Y_LOW, y_lo);
		write_limit(gxyb_pkg::REG_Y_HIGH, y_hi);
	endtask

	// Waits until every queued character is in and every verdict is out, or the
	// drain bound is reached, then lets the block run on idle before returning.
	task automatic settle_block();
		int spins;
		while (char_queue.size() != 0) begin
			@(posedge clk);
		end
		spins = 0;
		while (line_results_due.size() != 0 && spins < DRAIN_CYCLES) begin
			@(posedge clk);
			spins++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Character sender. A new item goes on offer only once the previous one
	// has been taken, and valid stays high until then.
	always @(negedge clk) begin
		if (!arst_n) begin
			char_bus.valid <= 1'b0;
		end else if (!char_busy) begin
			if (char_gap > 0) begin
				char_gap--;
				char_bus.valid     <= 1'b0;
				char_bus.line_byte <= gxyb_pkg::char_t'($urandom_range(0, 255));
				char_bus.last_byte <= 1'($urandom_range(0, 1));
			end else if (char_queue.size() != 0) begin
				char_bus.valid     <= 1'b1;
				char_bus.line_byte <= char_queue[0].code;
				char_bus.last_byte <= char_queue[0].last;
				char_busy = 1'b1;
				if (idle_enable && $urandom_range(0, 9) == 0) begin
					char_gap = $urandom_range(1, 13);
				end
			end else begin
				char_bus.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall bursts, plus the one long hold-off that
	// the stimulus asks for by raising hold_request.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap--;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
			if (idle_enable && $urandom_range(0, 11) == 0) begin
				ready_gap = $urandom_range(1, 13);
			end
		end
	end

	// Monitor. The character side is handled first, so a verdict is queued
	// before any result that could belong to it is looked at.
	always @(posedge clk) begin
		line_verdict_t expected_line;
		if (arst_n) begin
			if (char_bus.valid && char_bus.ready) begin
				void'(char_queue.pop_front());
				char_busy = 1'b0;
				chars_taken++;
				parse_char(char_bus.line_byte, char_bus.last_byte);
			end
			if (result_bus.valid && result_bus.ready) begin
				if (line_results_due.size() == 0) begin
					mismatches++;
					$display("%0t: line result arrived with none expected", $time);
				end else begin
					expected_line = line_results_due.pop_front();
					compare_field("in_window", expected_line.in_window, result_bus.in_window);
					compare_field("x_found", expected_line.sum.x_found, result_bus.x_found);
					compare_field("y_found", expected_line.sum.y_found, result_bus.y_found);
					compare_field("x_value", expected_line.sum.x_value, result_bus.x_value);
					compare_field("y_value", expected_line.sum.y_value, result_bus.y_value);
					compare_field("malformed", expected_line.sum.malformed,
						result_bus.malformed);
					lines_checked++;
					if (expected_line.in_window) begin
						lines_in_window++;
					end
					if (expected_line.sum.malformed) begin
						lines_malformed++;
					end
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		string pad_line;

		// Every input to the block is known from time zero on.
		arst_n             = 1'b0;
		cfg_write_en       = 1'b0;
		cfg_index          = gxyb_pkg::REG_X_LOW;
		cfg_data           = '0;
		char_bus.valid     = 1'b0;
		char_bus.line_byte = '0;
		char_bus.last_byte = 1'b0;
		result_bus.ready   = 1'b0;
		idle_enable        = 1'b1;
		window_limit[gxyb_pkg::REG_X_LOW]  = gxyb_pkg::X_LOW_RESET;
		window_limit[gxyb_pkg::REG_X_HIGH] = gxyb_pkg::X_HIGH_RESET;
		window_limit[gxyb_pkg::REG_Y_LOW]  = gxyb_pkg::Y_LOW_RESET;
		window_limit[gxyb_pkg::REG_Y_HIGH] = gxyb_pkg::Y_HIGH_RESET;
		start_line();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed lines under the reset window. In order: a plain line inside
		// the window; a negative fraction and an X right on its low limit; an
		// overlong integer part with too many fraction digits; leading zeros;
		// empty words; a second point; a minus after the first position; a
		// repeated axis; a Y letter running into an X number just past the
		// high limit; bytes at both ends of the range with a stray high byte;
		// a line that is only an axis letter; a single noise byte; and a line
		// running past the search limit, whose late Y word must be ignored.
		queue_text("X100 Y200");
		queue_text("Y-.5 X28");
		queue_text("X12345.6789");
		queue_text("X0009.9 Y0");
		queue_text("X Y-");
		queue_text("X1.2.3 Y50");
		queue_text("X1-2");
		queue_text("X50 X60 Y40 Y70");
		queue_text("X192.001Y");
		add_char(8'h00, 1'b0);
		add_char(8'hFF, 1'b0);
		add_char(gxyb_pkg::CH_X, 1'b0);
		add_char(gxyb_pkg::char_t'("7"), 1'b0);
		add_char(8'h80, 1'b1);
		queue_text("X");
		add_char(8'hFF, 1'b1);
		pad_line = "X50";
		repeat (LINE_BYTES + 6) pad_line = {pad_line, " "};
		pad_line = {pad_line, "Y"};
		queue_text(pad_line);
		queue_random_lines(300);
		settle_block();

		// Widest legal window on both axes.
		write_window(-25'sd9999999, 25'sd9999999, -25'sd9999999, 25'sd9999999);
		queue_random_lines(300);
		settle_block();

		// A random window around the origin, often narrow.
		write_window(gxyb_pkg::value_t'(int'($urandom_range(0, 400000)) - 200000),
			gxyb_pkg::value_t'(int'($urandom_range(0, 400000)) - 200000
				+ int'($urandom_range(0, 200000))),
			gxyb_pkg::value_t'(int'($urandom_range(0, 400000)) - 200000),
			gxyb_pkg::value_t'(int'($urandom_range(0, 400000)) - 200000
				+ int'($urandom_range(0, 200000))));
		queue_random_lines(300);
		settle_block();

		// Register values at the ends of the 25-bit range, reversed on X, and
		// a reversed Y window one thousandth wide.
		write_window(25'sh0FFFFFF, 25'sh1000000, 25'sd5000, 25'sd4999);
		queue_random_lines(300);
		settle_block();

		// A zero-width X window at the origin. The whole phase is queued before
		// the long hold-off starts, so the sender keeps offering items while
		// the result register stays full and the block stalls its input.
		write_window(25'sd0, 25'sd0, -25'sd1000, 25'sd1000);
		queue_random_lines(300);
		hold_request = 1'b1;
		settle_block();

		// Back to the reset window at full rate, with no idling on either side.
		write_window(gxyb_pkg::X_LOW_RESET, gxyb_pkg::X_HIGH_RESET,
			gxyb_pkg::Y_LOW_RESET, gxyb_pkg::Y_HIGH_RESET);
		idle_enable = 1'b0;
		queue_random_lines(200);
		settle_block();

		if (line_results_due.size() != 0) begin
			mismatches++;
			$display("%0t: %0d line results never arrived", $time, line_results_due.size());
		end
		$display("Checked %0d lines from %0d characters under six window settings.",
			lines_checked, chars_taken);
		$display("%0d lines fell inside the window, %0d were malformed; one %0d-cycle result stall.",
			lines_in_window, lines_malformed, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
